[hdl/stc_pkg.sv]
// Package for the sequential trigger capture engine.
// Holds sizes, op and status codes, and the structs passed between modules.
// No dependencies.
package stc_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int PROBE_COUNT  = 8;
    localparam int MAX_STAGES   = 8;

    localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int STAGE_W = 4;
    localparam int WORD_W  = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // op codes
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status / mode codes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WAIT    = 2'd1;
    localparam logic [1:0] MODE_CAPTURE = 2'd2;
    localparam logic [1:0] MODE_DONE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAGES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd3;

    localparam logic [CNT_W-1:0] LENGTH_RESET = CNT_W'(BUFFER_DEPTH);

    typedef struct packed {
        logic [1:0]         status;
        logic [STAGE_W-1:0] stage;
        logic [CNT_W-1:0]   count;
        logic               rvalid;
    } stc_info_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } stc_mem_req_t;

endpackage

[hdl/sequential_trigger_capture_top.sv]
// Top level of the sequential trigger capture engine.
// Instantiates stc_ctrl, stc_store and stc_out; uses stc_pkg.
//
//  channel | handshake          | contents
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | op, probes, use_trigger, read_address
//  out     | out_valid/out_stall| status, trigger_stage, captured_count,
//          |                    | read_data, read_valid
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One word per cycle while out_stall does not back up; the result passes through the
// registered memory read stage and then the output register.
// Reset clears control state and config registers; the store is not cleared.
// out_stall backs up into in_stall once both result stages are full.
module sequential_trigger_capture_top
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [7:0]           probes,
    input  logic                 use_trigger,
    input  logic [11:0]          read_address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [3:0]           trigger_stage,
    output logic [12:0]          captured_count,
    output logic [7:0]           read_data,
    output logic                 read_valid,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic         accept;
    stc_info_t    info;
    stc_mem_req_t mem_req;
    logic [WORD_W-1:0] rdata;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    stc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .op           (op),
        .probes       (probes),
        .use_trigger  (use_trigger),
        .read_address (read_address),
        .info         (info),
        .mem_req      (mem_req)
    );

    stc_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    stc_out u_out
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .info           (info),
        .rdata          (rdata),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .trigger_stage  (trigger_stage),
        .captured_count (captured_count),
        .read_data      (read_data),
        .read_valid     (read_valid)
    );

endmodule

[hdl/stc_ctrl.sv]
// Capture control: config registers, trigger stage matching, write pointer.
// Issues write and read requests to the sample store. Uses stc_pkg.
module stc_ctrl
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [1:0]           op,
    input  logic [7:0]           probes,
    input  logic                 use_trigger,
    input  logic [ADDR_W-1:0]    read_address,
    output stc_info_t            info,
    output stc_mem_req_t         mem_req
);

    localparam logic [STAGE_W-1:0] MAX_ST = STAGE_W'(MAX_STAGES);
    localparam logic [WORD_W-1:0]  PROBE_MASK = WORD_W'((1 << PROBE_COUNT) - 1);

    logic [CFG_W-1:0]   masks_reg;
    logic [CFG_W-1:0]   values_reg;
    logic [STAGE_W-1:0] stages_reg;
    logic [CNT_W-1:0]   length_reg;

    logic [1:0]         mode_reg, mode_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [CNT_W-1:0]   widx_reg, widx_next;

    logic [STAGE_W-1:0] eff_stages;
    logic [CNT_W-1:0]   eff_length;
    logic [WORD_W-1:0]  sample;
    logic [WORD_W-1:0]  st_mask;
    logic [WORD_W-1:0]  st_value;
    logic [2:0]         k;
    logic [STAGE_W-1:0] stage_inc;
    logic [CNT_W-1:0]   widx_inc;
    logic               do_store;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg  <= '0;
            values_reg <= '0;
            stages_reg <= '0;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASKS:  masks_reg  <= cfg_data;
                REG_VALUES: values_reg <= cfg_data;
                REG_STAGES: stages_reg <= cfg_data[STAGE_W-1:0];
                REG_LENGTH: length_reg <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        eff_stages = (stages_reg > MAX_ST) ? MAX_ST : stages_reg;
        if (length_reg == '0)
            eff_length = CNT_W'(1);
        else if (length_reg > LENGTH_RESET)
            eff_length = LENGTH_RESET;
        else
            eff_length = length_reg;

        sample    = probes & PROBE_MASK;
        k         = stage_reg[2:0];
        st_mask   = masks_reg[8*k +: 8];
        st_value  = values_reg[8*k +: 8];
        stage_inc = stage_reg + STAGE_W'(1);
        widx_inc  = widx_reg + CNT_W'(1);

        mode_next  = mode_reg;
        stage_next = stage_reg;
        widx_next  = widx_reg;
        do_store   = 1'b0;

        case (op)
            OP_ARM:
            begin
                widx_next  = '0;
                stage_next = '0;
                mode_next  = (use_trigger && eff_stages != '0) ? MODE_WAIT : MODE_CAPTURE;
            end
            OP_SAMPLE:
            begin
                if (mode_reg == MODE_WAIT)
                begin
                    if ((sample & st_mask) == st_value)
                    begin
                        stage_next = stage_inc;
                        // last stage matched: this sample is capture word 0
                        if (stage_inc >= eff_stages)
                            do_store = 1'b1;
                    end
                end
                else if (mode_reg == MODE_CAPTURE)
                begin
                    do_store = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_store)
        begin
            widx_next = widx_inc;
            mode_next = (widx_inc >= eff_length) ? MODE_DONE : MODE_CAPTURE;
        end

        info.status = mode_next;
        info.stage  = stage_next;
        info.count  = widx_next;
        info.rvalid = (op == OP_READ) && ({1'b0, read_address} < widx_reg);

        mem_req.we    = accept && do_store;
        mem_req.waddr = widx_reg[ADDR_W-1:0];
        mem_req.wdata = sample;
        mem_req.re    = accept && (op == OP_READ);
        mem_req.raddr = read_address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            stage_reg <= '0;
            widx_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            stage_reg <= stage_next;
            widx_reg  <= widx_next;
        end
    end

endmodule

[hdl/stc_store.sv]
// Sample store: single-port-write, single-read synchronous memory.
// Read data is registered. Uses stc_pkg.
module stc_store
    import stc_pkg::*;
(
    input  logic              clk,
    input  stc_mem_req_t      mem_req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [BUFFER_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
            mem[mem_req.waddr] <= mem_req.wdata;
    end

    // holds until the next read, so a stalled read word stays put
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
            rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/stc_out.sv]
// Result path: one stage aligned with the memory read, then the output register.
// Generates input stall from output backpressure. Uses stc_pkg.
module stc_out
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  stc_info_t          info,
    input  logic [WORD_W-1:0]  rdata,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [STAGE_W-1:0] trigger_stage,
    output logic [CNT_W-1:0]   captured_count,
    output logic [WORD_W-1:0]  read_data,
    output logic               read_valid
);

    logic       s1_valid_reg;
    stc_info_t  s1_info_reg;
    logic       s1_adv;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [STAGE_W-1:0] stage_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic               rvalid_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_info_reg <= info;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg <= s1_info_reg.status;
            stage_reg  <= s1_info_reg.stage;
            count_reg  <= s1_info_reg.count;
            rvalid_reg <= s1_info_reg.rvalid;
            rdata_reg  <= s1_info_reg.rvalid ? rdata : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign trigger_stage  = stage_reg;
    assign captured_count = count_reg;
    assign read_data      = rdata_reg;
    assign read_valid     = rvalid_reg;

endmodule
